@@ hw/rtl/caf_pkg.sv @@
// Shared types, constants and the arctangent table of the attitude filter.
`timescale 1ns / 1ps

package caf_pkg;

  // CORDIC datapath widths and fixed-point formats
  localparam int XY_W      = 36;   // x/y working registers, inputs pre-scaled by 2^16
  localparam int Z_W       = 34;   // angle accumulator, Q.24 degrees
  localparam int TBL_FRAC  = 24;
  localparam int PRE_SHIFT = 16;
  localparam int TBL_IDX_W = 5;    // arctangent table holds 24 entries

  localparam logic signed [Z_W-1:0] Z_180 = 34'sd3019898880;  // 180 << 24

  // Configuration register indexes
  localparam logic [7:0] CFG_GYRO_STEP_GAIN = 8'd0;
  localparam logic [7:0] CFG_BLEND_WEIGHT   = 8'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROLL,
    S_PITCH,
    S_GMUL,
    S_GADD,
    S_BMUL_G,
    S_BMUL_A,
    S_BSUM,
    S_DONE
  } caf_state_t;

  typedef enum logic [1:0] {
    AX_YAW,
    AX_ROLL,
    AX_PITCH
  } caf_axis_t;

  // One arctangent request: start pulse and the two raw operands
  typedef struct packed {
    logic               start;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } caf_cordic_req_t;

  // atan(2^-i) in Q.24 degrees
  function automatic logic signed [Z_W-1:0] atan_q24(input logic [TBL_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/caf_cordic.sv @@
// Iterative vectoring CORDIC: atan2(y, x) in degrees, one micro-rotation per cycle.
`timescale 1ns / 1ps

module caf_cordic #(
  parameter int STEPS = 16,
  parameter int AFB   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  caf_pkg::caf_cordic_req_t         req,
  output logic                             done,
  output logic signed [caf_pkg::Z_W-1:0]   angle
);
  import caf_pkg::*;

  localparam int CNT_W = $clog2(STEPS);
  localparam int SH    = TBL_FRAC - AFB;
  localparam logic signed [Z_W-1:0] RND = Z_W'(1) <<< (SH - 1);

  logic                    busy;
  logic [CNT_W-1:0]        iter;
  logic signed [XY_W-1:0]  x, y;
  logic signed [Z_W-1:0]   z;
  logic                    zero_in;

  logic signed [XY_W-1:0]  x_init, y_init, xs, ys;
  logic signed [Z_W-1:0]   z_init;
  logic signed [XY_W-1:0]  dx, dy, x_next, y_next;
  logic signed [Z_W-1:0]   z_next, z_rnd, step_ang;
  logic                    last;

  // Pre-rotate a left-half vector by 180 degrees, then scale up
  always_comb begin
    xs = {{(XY_W-16){req.x[15]}}, req.x};
    ys = {{(XY_W-16){req.y[15]}}, req.y};
    z_init = '0;
    if (req.x[15]) begin
      xs = -xs;
      ys = -ys;
      z_init = req.y[15] ? -Z_180 : Z_180;
    end
    x_init = xs <<< PRE_SHIFT;
    y_init = ys <<< PRE_SHIFT;
  end

  always_comb begin
    dx       = y >>> iter;
    dy       = x >>> iter;
    step_ang = atan_q24(TBL_IDX_W'(iter));
    if (!y[XY_W-1] && (y != '0)) begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + step_ang;
    end else begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - step_ang;
    end
    z_rnd = (z_next + RND) >>> SH;
    last  = (iter == CNT_W'(STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= busy && last && !req.start;
      if (req.start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x       <= x_init;
      y       <= y_init;
      z       <= z_init;
      zero_in <= (req.x == '0) && (req.y == '0);
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
      if (last) begin
        angle <= zero_in ? '0 : z_rnd;
      end
    end
  end

  // A result only follows a run of iterations
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("cordic done without a running rotation");

  a_start_clears_iter: assert property (@(posedge clk) disable iff (rst)
    req.start |=> (busy && iter == '0))
    else $error("cordic start did not restart the iteration count");

  a_busy_drops_on_last: assert property (@(posedge clk) disable iff (rst)
    (busy && last && !req.start) |=> (!busy && done))
    else $error("cordic did not finish after the last step");

endmodule

@@ hw/rtl/complementary_attitude_filter_unit.sv @@
// Top level of the complementary attitude filter: sequencer, shared multiplier, registers.
`timescale 1ns / 1ps

// One raw IMU sample in, one attitude result out. Yaw integrates gyro z; roll and
// pitch blend the integrated gyro x/y with accelerometer angles atan2(ay, az) and
// -atan2(ax, az), taken from one iterative CORDIC that turns one micro-rotation
// per cycle and is used twice per sample. Angles are Q16.16 degrees (for the
// default ANGLE_FRAC_BITS) and saturate at the signed 32-bit limits. From acceptance
// to the result register a sample passes through two CORDIC runs of CORDIC_STEPS
// micro-rotations each, then three multiply/accumulate pairs for the gyro steps and
// two blends (gyro product, accelerometer product, sum) on one shared 34x25
// multiplier. The input side stays not ready through that work, so a new request
// is taken only once the previous sample is done, while its result may still wait
// in the output register. Configuration writes are always taken; write them only
// while the block is idle. Register 0 is the gyro step gain (Q0.24 degrees per LSB
// per sample), register 1 the gyro blend weight (Q1.16, values above 1.0 act as
// 1.0); writes to other indexes are dropped.
module complementary_attitude_filter_unit #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  // input sample stream
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [111:0]  s_tdata,    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                                    // temp_raw (16 bits each)
  // result stream
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [111:0]  m_tdata,    // yaw_deg (32), roll_deg (32), pitch_deg (32),
                                    // temp_centi (15), one zero pad bit
  // configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [23:0]   cfg_data
);
  import caf_pkg::*;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SH      = TBL_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [SUM_W-1:0] G_RND  = SUM_W'(1) <<< (SH - 1);
  localparam logic signed [SUM_W-1:0] B_RND  = SUM_W'(32768);
  localparam logic signed [SUM_W-1:0] MAX32  = SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] MIN32  = -MAX32 - SUM_W'(1);
  localparam logic [16:0]             W_ONE  = 17'd65536;
  localparam logic [19:0]             RECIP17 = 20'd986896;  // ceil(2^24 / 17)
  localparam logic signed [14:0]      T_OFS  = 15'sd3653;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > MAX32)      r = 32'sh7FFF_FFFF;
    else if (v < MIN32) r = 32'sh8000_0000;
    else                r = v[31:0];
    return r;
  endfunction

  // Control and configuration
  caf_state_t          state, state_next;
  caf_axis_t           axis;
  logic                blend_sel;   // 0 roll, 1 pitch
  logic [23:0]         gyro_step_gain;
  logic [16:0]         blend_weight;

  // Filter state
  logic signed [31:0]  yaw_est, roll_est, pitch_est;

  // Per-sample working registers
  logic signed [15:0]  accel_x_q, accel_z_q, rate_x_q, rate_y_q, rate_z_q, temp_raw_q;
  logic signed [Z_W-1:0] roll_acc, pitch_acc;
  logic signed [31:0]  roll_g, pitch_g;
  logic signed [PROD_W-1:0] prod, part;
  logic signed [14:0]  temp_q;

  // Output register
  logic signed [31:0]  yaw_out, roll_out, pitch_out;
  logic signed [14:0]  temp_out;

  // Shared multiplier operands
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  caf_cordic_req_t       cordic_req;
  logic                  cordic_done;
  logic signed [Z_W-1:0] cordic_angle;

  logic [16:0]         w_clamp;
  logic signed [31:0]  est_cur, gyro_sum, blend_res;
  logic signed [15:0]  rate_cur;
  logic                in_accept;

  caf_cordic #(
    .STEPS (CORDIC_STEPS),
    .AFB   (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .req   (cordic_req),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign w_clamp   = (blend_weight > W_ONE) ? W_ONE : blend_weight;

  // Pick the estimate and gyro axis for the current integration step
  always_comb begin
    unique case (axis)
      AX_YAW:   begin est_cur = yaw_est;   rate_cur = rate_z_q; end
      AX_ROLL:  begin est_cur = roll_est;  rate_cur = rate_x_q; end
      AX_PITCH: begin est_cur = pitch_est; rate_cur = rate_y_q; end
      default:  begin est_cur = yaw_est;   rate_cur = rate_z_q; end
    endcase
  end

  // Gyro step: round the Q.24 increment down to the angle format, add, saturate
  assign gyro_sum  = sat32($signed({{(SUM_W-32){est_cur[31]}}, est_cur})
                         + (($signed({prod[PROD_W-1], prod}) + G_RND) >>> SH));
  // Blend: weighted sum of the two products, round half up, saturate
  assign blend_res = sat32(($signed({part[PROD_W-1], part})
                           + $signed({prod[PROD_W-1], prod}) + B_RND) >>> 16);

  // Temperature: trunc(raw * 5 / 17) + 36.53 degrees, via a reciprocal multiply
  logic signed [18:0] t5;
  logic        [17:0] t5_mag;
  logic        [37:0] t_prod;
  logic        [13:0] t_quo;
  always_comb begin
    t5     = {{3{temp_raw_q[15]}}, temp_raw_q} + {temp_raw_q[15], temp_raw_q, 2'b00};
    t5_mag = t5[18] ? 18'(-t5) : t5[17:0];
    t_prod = t5_mag * RECIP17;
    t_quo  = t_prod[37:24];
  end

  // Sequencer: next state, CORDIC requests and multiplier operand selection
  always_comb begin
    state_next = state;
    cordic_req = '0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cordic_req.start = 1'b1;
          cordic_req.y     = s_tdata[31:16];   // accel_y
          cordic_req.x     = s_tdata[47:32];   // accel_z
          state_next       = S_ROLL;
        end
      end
      S_ROLL: begin
        if (cordic_done) begin
          cordic_req.start = 1'b1;
          cordic_req.y     = accel_x_q;
          cordic_req.x     = accel_z_q;
          state_next       = S_PITCH;
        end
      end
      S_PITCH: begin
        if (cordic_done) state_next = S_GMUL;
      end
      S_GMUL: begin
        mul_a      = {{(MUL_A_W-16){rate_cur[15]}}, rate_cur};
        mul_b      = {1'b0, gyro_step_gain};
        state_next = S_GADD;
      end
      S_GADD: begin
        state_next = (axis == AX_PITCH) ? S_BMUL_G : S_GMUL;
      end
      S_BMUL_G: begin
        mul_a = blend_sel ? {{(MUL_A_W-32){pitch_g[31]}}, pitch_g}
                          : {{(MUL_A_W-32){roll_g[31]}}, roll_g};
        mul_b = {{(MUL_B_W-17){1'b0}}, w_clamp};
        state_next = S_BMUL_A;
      end
      S_BMUL_A: begin
        mul_a      = blend_sel ? pitch_acc : roll_acc;
        mul_b      = {{(MUL_B_W-17){1'b0}}, W_ONE - w_clamp};
        state_next = S_BSUM;
      end
      S_BSUM: begin
        state_next = blend_sel ? S_DONE : S_BMUL_G;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control, configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      axis           <= AX_YAW;
      blend_sel      <= 1'b0;
      m_tvalid       <= 1'b0;
      gyro_step_gain <= 24'd5115;
      blend_weight   <= 17'd62415;
      yaw_est        <= '0;
      roll_est       <= '0;
      pitch_est      <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_GYRO_STEP_GAIN: gyro_step_gain <= cfg_data;
          CFG_BLEND_WEIGHT:   blend_weight   <= cfg_data[16:0];
          default: ;   // drop writes to unknown registers
        endcase
      end
      // Load a new result, or drop the flag once the old one is taken
      if (state == S_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready)                   m_tvalid <= 1'b0;
      unique case (state)
        S_PITCH: begin
          axis      <= AX_YAW;
          blend_sel <= 1'b0;
        end
        S_GADD: begin
          if (axis == AX_YAW) begin
            yaw_est <= gyro_sum;
            axis    <= AX_ROLL;
          end else if (axis == AX_ROLL) begin
            axis <= AX_PITCH;
          end
        end
        S_BSUM: begin
          if (blend_sel) pitch_est <= blend_res;
          else           roll_est  <= blend_res;
          blend_sel <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_accept) begin
      accel_x_q  <= s_tdata[15:0];
      accel_z_q  <= s_tdata[47:32];
      rate_x_q   <= s_tdata[63:48];
      rate_y_q   <= s_tdata[79:64];
      rate_z_q   <= s_tdata[95:80];
      temp_raw_q <= s_tdata[111:96];
    end
    if (state == S_ROLL) begin
      temp_q <= t5[18] ? (T_OFS - $signed({1'b0, t_quo})) : (T_OFS + $signed({1'b0, t_quo}));
      if (cordic_done) roll_acc <= cordic_angle;
    end
    if (state == S_PITCH && cordic_done) pitch_acc <= -cordic_angle;
    if (state == S_GADD) begin
      if (axis == AX_ROLL)  roll_g  <= gyro_sum;
      if (axis == AX_PITCH) pitch_g <= gyro_sum;
    end
    if (state == S_BMUL_A) part <= prod;
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      yaw_out   <= yaw_est;
      roll_out  <= roll_est;
      pitch_out <= pitch_est;
      temp_out  <= temp_q;
    end
  end

  assign m_tdata = {1'b0, temp_out, pitch_out, roll_out, yaw_out};

  a_accept_starts_roll: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_ROLL))
    else $error("accepted request did not start the roll rotation");

  a_cordic_done_expected: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> (state == S_ROLL || state == S_PITCH))
    else $error("cordic result arrived outside the angle phases");

  a_yaw_only_in_gadd: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && yaw_est != $past(yaw_est)) |-> ($past(state) == S_GADD))
    else $error("yaw estimate changed outside the integration step");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result presented without finishing a sample");

endmodule

@@ dv/complementary_attitude_filter_unit_tb.sv @@
// Self-checking testbench for the complementary attitude filter unit.
`timescale 1ns / 1ps

module complementary_attitude_filter_unit_tb;
  import caf_pkg::*;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ANGLE_SHIFT     = TBL_FRAC - ANGLE_FRAC_BITS;
  localparam longint ROUND_HALF  = 64'sd1 <<< (ANGLE_SHIFT - 1);
  localparam longint HALF_TURN   = 64'sd180 <<< TBL_FRAC;
  localparam longint FULL_WEIGHT = 64'sd65536;

  // indexes outside the register map; writes there must be dropped
  localparam logic [7:0] CFG_UNMAPPED_LO = 8'd2;
  localparam logic [7:0] CFG_UNMAPPED_HI = 8'hFF;

  localparam logic [23:0] GAIN_RESET   = 24'd5115;
  localparam logic [23:0] WEIGHT_RESET = 24'd62415;

  // atan(2^-i) in Q.24 degrees
  localparam longint ATAN_STEP_DEG [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  // request fields, accel_x in the lowest bits
  typedef struct packed {
    logic signed [15:0] temp_raw;
    logic signed [15:0] rate_z;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_x;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
  } imu_sample_t;

  typedef struct packed {
    logic               pad;
    logic signed [14:0] temp_centi;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] roll_deg;
    logic signed [31:0] yaw_deg;
  } attitude_t;

  typedef struct {
    int ax, ay, az, gx, gy, gz, tr;
    bit pinned;                       // result typed in below, not predicted
    int yaw, roll, pitch, temp;
  } directed_row_t;

  typedef struct {
    logic [23:0] gain;
    logic [23:0] weight;
    bit          junk;
    logic [7:0]  junk_idx;
    int unsigned send_idle;
    int unsigned recv_stall;
    int unsigned count;
  } phase_t;

  localparam int N_DIRECTED = 22;
  localparam int N_PHASES   = 8;

  // Rows with pinned results start from the zero state, so only temperature moves.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{0, 0, 0, 0, 0, 0, 0,                 1'b1, 0, 0, 0, 3653},
    '{0, 0, 0, 0, 0, 0, 32767,             1'b1, 0, 0, 0, 13290},
    '{0, 0, 0, 0, 0, 0, -32768,            1'b1, 0, 0, 0, -5984},
    '{0, 0, 0, 0, 0, 0, -1,                1'b1, 0, 0, 0, 3653},
    '{0, 0, 0, 0, 0, 0, 17,                1'b1, 0, 0, 0, 3658},
    '{0, 0, 0, 0, 0, 0, -18,               1'b1, 0, 0, 0, 3648},
    // negative z with zero numerator: half turn
    '{0, 0, -16384, 0, 0, 0, 100,          1'b0, 0, 0, 0, 0},
    '{100, 5000, -16384, 0, 0, 0, 0,       1'b0, 0, 0, 0, 0},
    '{-100, -5000, -16384, 0, 0, 0, 0,     1'b0, 0, 0, 0, 0},
    '{16384, 16384, 0, 0, 0, 0, 0,         1'b0, 0, 0, 0, 0},
    '{-16384, -16384, 0, 0, 0, 0, 0,       1'b0, 0, 0, 0, 0},
    '{32767, 32767, 32767, 32767, 32767, 32767, 1000,          1'b0, 0, 0, 0, 0},
    '{-32768, -32768, -32768, -32768, -32768, -32768, -1000,   1'b0, 0, 0, 0, 0},
    '{32767, -32768, 1, 0, 0, 0, 0,        1'b0, 0, 0, 0, 0},
    '{-32768, 32767, -1, 0, 0, 0, 0,       1'b0, 0, 0, 0, 0},
    '{0, 0, 0, 32767, -32768, 32767, 0,    1'b0, 0, 0, 0, 0},
    '{0, 0, 16384, 200, -150, 50, 0,       1'b0, 0, 0, 0, 0},
    '{1, -1, 16384, 0, 0, 0, 0,            1'b0, 0, 0, 0, 0},
    '{2000, -3000, 16000, -40, 33, 1, 500, 1'b0, 0, 0, 0, 0},
    '{0, 1, 0, 0, 0, 0, 0,                 1'b0, 0, 0, 0, 0},
    '{-1, 0, 0, 0, 0, 0, 0,                1'b0, 0, 0, 0, 0},
    '{0, 0, 0, 32767, 32767, 32767, 0,     1'b0, 0, 0, 0, 0}
  };

  // register settings crossed with idle/stall profiles
  phase_t phases [N_PHASES] = '{
    '{GAIN_RESET,   WEIGHT_RESET, 1'b0, CFG_UNMAPPED_LO, 0,  0,  300},
    '{24'hFFFFFF,   24'd65536,    1'b0, CFG_UNMAPPED_LO, 77, 0,  150},
    '{24'd0,        24'd0,        1'b0, CFG_UNMAPPED_LO, 0,  77, 200},
    '{24'hFFFFFF,   24'hFFFFFF,   1'b1, CFG_UNMAPPED_LO, 9,  9,  150},
    '{24'd1,        24'd1,        1'b0, CFG_UNMAPPED_LO, 0,  0,  150},
    '{GAIN_RESET,   WEIGHT_RESET, 1'b1, CFG_UNMAPPED_HI, 9,  9,  250},
    '{24'd300000,   24'd32768,    1'b0, CFG_UNMAPPED_LO, 77, 0,  200},
    '{GAIN_RESET,   24'd65535,    1'b0, CFG_UNMAPPED_LO, 0,  77, 250}
  };

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;     // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, temp_raw
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;     // yaw_deg, roll_deg, pitch_deg, temp_centi, zero pad
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [23:0]  cfg_data;

  // predictor state and register copies
  logic signed [31:0] yaw_est, roll_est, pitch_est;
  longint             step_gain;
  longint             gyro_weight;

  attitude_t   pending_attitudes [$];
  int unsigned samples_accepted;
  int unsigned attitudes_seen;
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  complementary_attitude_filter_unit #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint round_off(input longint v);
    return (v + ROUND_HALF) >>> ANGLE_SHIFT;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  // vectoring arctangent of num/den in degrees, ANGLE_FRAC_BITS fraction bits
  function automatic longint accel_angle(input longint num, input longint den);
    longint x, y, z, dx, dy;
    int     i;
    x = den;
    y = num;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // fold the left half plane over by a half turn
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    x = x <<< PRE_SHIFT;
    y = y <<< PRE_SHIFT;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_STEP_DEG[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_STEP_DEG[i];
      end
    end
    return round_off(z);
  endfunction

  function automatic logic signed [31:0] gyro_step(input logic signed [31:0] est,
                                                   input longint rate);
    return clamp32(longint'(est) + round_off(rate * step_gain));
  endfunction

  function automatic logic signed [31:0] fuse(input logic signed [31:0] gyro_angle,
                                              input longint acc_angle);
    longint w;
    w = (gyro_weight > FULL_WEIGHT) ? FULL_WEIGHT : gyro_weight;
    return clamp32((w * longint'(gyro_angle) + (FULL_WEIGHT - w) * acc_angle + 32768) >>> 16);
  endfunction

  // Update the estimates for one accepted sample and return the attitude it yields.
  function automatic attitude_t advance_attitude(input imu_sample_t smp);
    attitude_t          r;
    longint             roll_acc, pitch_acc, t;
    logic signed [31:0] roll_gyro, pitch_gyro;
    r         = '0;
    roll_acc  = accel_angle(longint'(smp.accel_y), longint'(smp.accel_z));
    pitch_acc = -accel_angle(longint'(smp.accel_x), longint'(smp.accel_z));
    yaw_est    = gyro_step(yaw_est, longint'(smp.rate_z));
    roll_gyro  = gyro_step(roll_est, longint'(smp.rate_x));
    pitch_gyro = gyro_step(pitch_est, longint'(smp.rate_y));
    roll_est   = fuse(roll_gyro, roll_acc);
    pitch_est  = fuse(pitch_gyro, pitch_acc);
    // division truncates toward zero
    t = (longint'(smp.temp_raw) * 5) / 17 + 3653;
    r.yaw_deg    = yaw_est;
    r.roll_deg   = roll_est;
    r.pitch_deg  = pitch_est;
    r.temp_centi = 15'(t);
    return r;
  endfunction

  function automatic logic [15:0] corner_value();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return 16'($urandom());
    endcase
  endfunction

  // mostly plausible sensor readings, plus raw noise and corner values
  function automatic imu_sample_t random_sample();
    imu_sample_t smp;
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 25) begin
      smp = 112'({$urandom(), $urandom(), $urandom(), $urandom()});
    end else if (mode < 40) begin
      smp = {corner_value(), corner_value(), corner_value(), corner_value(),
             corner_value(), corner_value(), corner_value()};
    end else begin
      smp.accel_x  = 16'(int'($urandom_range(6000)) - 3000);
      smp.accel_y  = 16'(int'($urandom_range(6000)) - 3000);
      smp.accel_z  = 16'(16384 + int'($urandom_range(6000)) - 3000);
      if ($urandom_range(9) == 0) smp.accel_z = -smp.accel_z;
      smp.rate_x   = 16'(int'($urandom_range(2000)) - 1000);
      smp.rate_y   = 16'(int'($urandom_range(2000)) - 1000);
      smp.rate_z   = 16'(int'($urandom_range(2000)) - 1000);
      smp.temp_raw = 16'(int'($urandom_range(10000)) - 5000);
    end
    return smp;
  endfunction

  // Hold the request until taken, then log its expected attitude.
  task automatic send_sample(input imu_sample_t smp, input bit pinned,
                             input attitude_t pinned_r);
    attitude_t model_r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 112'({$urandom(), $urandom(), $urandom(), $urandom()});
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model_r = advance_attitude(smp);
    pending_attitudes.push_back(pinned ? pinned_r : model_r);
    samples_accepted++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GYRO_STEP_GAIN: step_gain   = longint'(data);
      CFG_BLEND_WEIGHT:   gyro_weight = longint'(data[16:0]);
      default: ;
    endcase
  endtask

  task automatic wait_for_results();
    while (attitudes_seen < samples_accepted) @(posedge clk);
  endtask

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every accepted result against the oldest pending attitude.
  always @(posedge clk) begin
    attitude_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_attitudes.size() == 0) begin
        $error("unexpected result %h with nothing pending", m_tdata);
        fail_count++;
      end else begin
        want = pending_attitudes.pop_front();
        check_field("yaw_deg", longint'(want.yaw_deg), longint'(got.yaw_deg));
        check_field("roll_deg", longint'(want.roll_deg), longint'(got.roll_deg));
        check_field("pitch_deg", longint'(want.pitch_deg), longint'(got.pitch_deg));
        check_field("temp_centi", longint'(want.temp_centi), longint'(got.temp_centi));
        check_field("pad", longint'(want.pad), longint'(got.pad));
      end
      attitudes_seen++;
    end
  end

  initial begin
    imu_sample_t   smp;
    attitude_t     pinned_r;
    directed_row_t row;
    phase_t        ph;
    int            n;

    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_count     = 0;
    samples_accepted = 0;
    attitudes_seen   = 0;
    yaw_est     = '0;
    roll_est    = '0;
    pitch_est   = '0;
    step_gain   = longint'(GAIN_RESET);
    gyro_weight = longint'(WEIGHT_RESET);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed samples under the reset register values
    for (n = 0; n < N_DIRECTED; n++) begin
      row = directed_rows[n];
      smp.accel_x  = 16'(row.ax);
      smp.accel_y  = 16'(row.ay);
      smp.accel_z  = 16'(row.az);
      smp.rate_x   = 16'(row.gx);
      smp.rate_y   = 16'(row.gy);
      smp.rate_z   = 16'(row.gz);
      smp.temp_raw = 16'(row.tr);
      pinned_r            = '0;
      pinned_r.yaw_deg    = 32'(row.yaw);
      pinned_r.roll_deg   = 32'(row.roll);
      pinned_r.pitch_deg  = 32'(row.pitch);
      pinned_r.temp_centi = 15'(row.temp);
      send_sample(smp, row.pinned, pinned_r);
    end
    s_tvalid <= 1'b0;
    wait_for_results();

    // random phases; registers change only with the block drained
    foreach (phases[p]) begin
      ph = phases[p];
      write_reg(CFG_GYRO_STEP_GAIN, ph.gain);
      write_reg(CFG_BLEND_WEIGHT, ph.weight);
      if (ph.junk) write_reg(ph.junk_idx, 24'($urandom()));
      cfg_valid      <= 1'b0;
      send_idle_pct  = ph.send_idle;
      recv_stall_pct = ph.recv_stall;
      for (n = 0; n < int'(ph.count); n++) send_sample(random_sample(), 1'b0, '0);
      s_tvalid <= 1'b0;
      wait_for_results();
    end

    recv_stall_pct = 0;
    repeat (64) @(posedge clk);
    if (pending_attitudes.size() != 0) begin
      $error("%0d expected results never arrived", pending_attitudes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
